@@ hw/rtl/aepp_pkg.sv @@
// Shared constants and types for the audio PES packetizer.
`timescale 1ns / 1ps
package aepp_pkg;

    localparam int unsigned CFG_W      = 48;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned SPF_W      = 16;
    localparam int unsigned RATE_W     = 18;
    localparam int unsigned FSZ_W      = 16;
    localparam int unsigned OFS_W      = 33;
    localparam int unsigned PTS_W      = 48;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned TICK_W     = 17;
    localparam int unsigned PROD_W     = CNT_W + SPF_W;
    localparam int unsigned SCALED_W   = PROD_W + TICK_W + 1;

    localparam logic [TICK_W-1:0] TICKS   = TICK_W'(90000);
    localparam logic [PTS_W-1:0]  PTS_MAX = {PTS_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPF    = 3'd0,
        REG_RATE   = 3'd1,
        REG_FSZ    = 3'd2,
        REG_OFFSET = 3'd3,
        REG_LIMIT  = 3'd4,
        REG_SID    = 3'd5
    } t_reg_idx;

    // Request to the PTS unit
    typedef struct packed {
        logic                start;
        logic [CNT_W-1:0]    count;
        logic [SPF_W-1:0]    spf;
        logic [RATE_W-1:0]   rate;
        logic [OFS_W-1:0]    offset;
    } t_pts_req;

    // Answer from the PTS unit
    typedef struct packed {
        logic                done;
        logic [PTS_W-1:0]    pts;
    } t_pts_rsp;

endpackage

@@ hw/rtl/aepp_pts_unit.sv @@
// Iterative PTS step unit: offset + floor(count * spf * 90000 / rate), saturated.
`timescale 1ns / 1ps
module aepp_pts_unit
    import aepp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_pts_req i_req,
    output t_pts_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_DIV,
        S_SUM
    } t_state;

    t_state                r_state;
    logic [6:0]            r_cnt;
    logic [CNT_W-1:0]      r_k;
    logic [SPF_W-1:0]      r_spf;
    logic [RATE_W-1:0]     r_div;
    logic [OFS_W-1:0]      r_ofs;
    logic [PROD_W-1:0]     r_a;
    logic [SCALED_W-1:0]   r_acc;
    logic [RATE_W-1:0]     r_rem;
    logic                  r_done;
    logic [PTS_W-1:0]      r_pts;

    logic [RATE_W:0]       rem2;
    logic                  ge;
    logic [SCALED_W:0]     sum;

    // Restoring division step and final offset add
    assign rem2 = {r_rem, r_acc[SCALED_W-1]};
    assign ge   = (rem2 >= {1'b0, r_div});
    assign sum  = {1'b0, r_acc} + (SCALED_W+1)'(r_ofs);

    // Sequence multiply, constant scale, divide and sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_k     <= i_req.count;
                        r_spf   <= i_req.spf;
                        r_div   <= (i_req.rate == '0) ? RATE_W'(1) : i_req.rate;
                        r_ofs   <= i_req.offset;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_a     <= PROD_W'(r_k) * PROD_W'(r_spf);
                    r_acc   <= '0;
                    r_cnt   <= 7'(TICK_W - 1);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_acc <= {r_acc[SCALED_W-2:0], 1'b0}
                           + (TICKS[r_cnt[4:0]] ? SCALED_W'(r_a) : '0);
                    if (r_cnt == '0) begin
                        r_cnt   <= 7'(SCALED_W - 1);
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? RATE_W'(rem2 - {1'b0, r_div}) : rem2[RATE_W-1:0];
                    r_acc <= {r_acc[SCALED_W-2:0], ge};
                    if (r_cnt == '0) begin
                        r_state <= S_SUM;
                    end else begin
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                S_SUM: begin
                    r_pts   <= (sum[SCALED_W:PTS_W] != '0) ? PTS_MAX : sum[PTS_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.pts  = r_pts;

endmodule

@@ hw/rtl/audio_es_to_pes_packetizer.sv @@
// Top level: audio elementary stream to PES packetizer (MPEG audio / AC-3).
// A frame byte reaches the output register in the cycle after it is taken; the next one
// waits until that register is empty. The third byte starts the PTS unit (multiply, 17
// scale steps, 66 divide steps, sum); then the 17 header, held and third bytes leave one
// per cycle unless stalled; input stall stays high while the header is built and sent.
// Synchronous active-low reset returns to sync hunting and loads default registers.
`timescale 1ns / 1ps
module audio_es_to_pes_packetizer
    import aepp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_in_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_packet_end,
    output logic                 o_sync_error
);

    typedef enum logic [3:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_THIRD,
        PH_CALC,
        PH_HDR,
        PH_BODY,
        PH_PAD,
        PH_NEXT0,
        PH_NEXT1,
        PH_STOP
    } t_phase;

    // Configuration registers
    logic [SPF_W-1:0]  r_spf;
    logic [RATE_W-1:0] r_rate;
    logic [FSZ_W-1:0]  r_fsz;
    logic [OFS_W-1:0]  r_ofs;
    logic [PTS_W-1:0]  r_limit;
    logic [7:0]        r_sid_cfg;

    // Datapath state
    t_phase            r_phase;
    logic              r_mpeg;
    logic [15:0]       r_held;
    logic [15:0]       r_pos;
    logic [2:0]        r_pad;
    logic [CNT_W-1:0]  r_fcnt;
    logic [PTS_W-1:0]  r_pts;
    logic [4:0]        r_hidx;
    logic              r_last_end;
    logic [7:0]        r_b2;
    logic [7:0]        r_sid;
    logic [15:0]       r_len;
    logic [OFS_W-1:0]  r_t;

    // Output register
    logic              r_ov;
    logic [7:0]        r_ob;
    logic              r_oe;
    logic              r_oerr;

    t_pts_req          pts_req;
    t_pts_rsp          pts_rsp;

    logic              in_acc;
    logic              out_free;
    logic              sync_mp;
    logic              sync_ac;
    logic [FSZ_W-1:0]  fsz;
    logic [2:0]        pad_new;
    logic [7:0]        hdr_byte;
    logic              limit_hit;

    assign out_free = !r_ov || !i_stall;
    assign o_stall  = !((r_phase == PH_STOP) ||
                        (!r_ov && r_phase != PH_CALC && r_phase != PH_HDR));
    assign in_acc   = i_valid && !o_stall;

    assign sync_mp  = (r_held[7:0] == 8'hFF) && (i_in_byte[7:5] == 3'h7);
    assign sync_ac  = (r_held[7:0] == 8'h0B) && (i_in_byte == 8'h77);
    assign fsz      = (r_fsz < FSZ_W'(3)) ? FSZ_W'(3) : r_fsz;
    assign pad_new  = (r_mpeg && i_in_byte[1]) ? ((r_held[2:1] == 2'b11) ? 3'd4 : 3'd1)
                                               : 3'd0;
    assign limit_hit = (r_limit != '0) && (r_pts >= r_limit);

    // Request a new PTS when the third frame byte is taken
    assign pts_req.start  = in_acc && (r_phase == PH_THIRD);
    assign pts_req.count  = r_fcnt + CNT_W'(1);
    assign pts_req.spf    = r_spf;
    assign pts_req.rate   = r_rate;
    assign pts_req.offset = r_ofs;

    aepp_pts_unit u_pts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (pts_req),
        .o_rsp   (pts_rsp)
    );

    // Select header byte by position
    always_comb begin
        case (r_hidx)
            5'd0:    hdr_byte = 8'h00;
            5'd1:    hdr_byte = 8'h00;
            5'd2:    hdr_byte = 8'h01;
            5'd3:    hdr_byte = r_sid;
            5'd4:    hdr_byte = r_len[15:8];
            5'd5:    hdr_byte = r_len[7:0];
            5'd6:    hdr_byte = 8'h81;
            5'd7:    hdr_byte = 8'h80;
            5'd8:    hdr_byte = 8'h05;
            5'd9:    hdr_byte = {4'h2, r_t[32:30], 1'b1};
            5'd10:   hdr_byte = r_t[29:22];
            5'd11:   hdr_byte = {r_t[21:15], 1'b1};
            5'd12:   hdr_byte = r_t[14:7];
            5'd13:   hdr_byte = {r_t[6:0], 1'b1};
            5'd14:   hdr_byte = r_held[15:8];
            5'd15:   hdr_byte = r_held[7:0];
            default: hdr_byte = r_b2;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spf     <= SPF_W'(1152);
            r_rate    <= RATE_W'(48000);
            r_fsz     <= FSZ_W'(768);
            r_ofs     <= '0;
            r_limit   <= '0;
            r_sid_cfg <= 8'd192;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPF:    r_spf     <= i_cfg_data[SPF_W-1:0];
                REG_RATE:   r_rate    <= i_cfg_data[RATE_W-1:0];
                REG_FSZ:    r_fsz     <= i_cfg_data[FSZ_W-1:0];
                REG_OFFSET: r_ofs     <= i_cfg_data[OFS_W-1:0];
                REG_LIMIT:  r_limit   <= i_cfg_data[PTS_W-1:0];
                REG_SID:    r_sid_cfg <= i_cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // Sequence frames and drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT0;
            r_mpeg  <= 1'b0;
            r_held  <= '0;
            r_pos   <= '0;
            r_pad   <= '0;
            r_fcnt  <= '0;
            r_pts   <= '0;
            r_hidx  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_phase)
                PH_HUNT0, PH_NEXT0: begin
                    if (in_acc) begin
                        r_held  <= {8'h00, i_in_byte};
                        r_phase <= (r_phase == PH_HUNT0) ? PH_HUNT1 : PH_NEXT1;
                    end
                end
                PH_HUNT1: begin
                    if (in_acc) begin
                        if (sync_mp || sync_ac) begin
                            r_mpeg  <= sync_mp;
                            r_held  <= {r_held[7:0], i_in_byte};
                            r_pts   <= PTS_W'(r_ofs);
                            r_phase <= PH_THIRD;
                        end else begin
                            r_held <= {8'h00, i_in_byte};
                        end
                    end
                end
                PH_NEXT1: begin
                    if (in_acc) begin
                        if (r_mpeg ? sync_mp : sync_ac) begin
                            r_held  <= {r_held[7:0], i_in_byte};
                            r_phase <= PH_THIRD;
                        end else begin
                            r_ov    <= 1'b1;
                            r_ob    <= 8'h00;
                            r_oe    <= 1'b0;
                            r_oerr  <= 1'b1;
                            r_phase <= PH_STOP;
                        end
                    end
                end
                PH_THIRD: begin
                    if (in_acc) begin
                        r_pad      <= pad_new;
                        r_b2       <= i_in_byte;
                        r_sid      <= r_sid_cfg;
                        r_len      <= fsz + 16'd8 + 16'(pad_new);
                        r_t        <= r_pts[OFS_W-1:0];
                        r_pos      <= fsz - FSZ_W'(3);
                        r_last_end <= (fsz == FSZ_W'(3)) && (pad_new == 3'd0);
                        r_fcnt     <= r_fcnt + CNT_W'(1);
                        r_hidx     <= '0;
                        r_phase    <= PH_CALC;
                    end
                end
                PH_CALC: begin
                    if (pts_rsp.done) begin
                        r_pts   <= pts_rsp.pts;
                        r_phase <= PH_HDR;
                    end
                end
                PH_HDR: begin
                    if (out_free) begin
                        r_ov   <= 1'b1;
                        r_ob   <= hdr_byte;
                        r_oerr <= 1'b0;
                        r_oe   <= (r_hidx == 5'd16) && r_last_end;
                        r_hidx <= r_hidx + 5'd1;
                        if (r_hidx == 5'd16) begin
                            if (r_pos != '0) begin
                                r_phase <= PH_BODY;
                            end else if (r_pad != '0) begin
                                r_phase <= PH_PAD;
                            end else begin
                                r_phase <= limit_hit ? PH_STOP : PH_NEXT0;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (in_acc) begin
                        r_pos  <= r_pos - 16'd1;
                        r_ov   <= 1'b1;
                        r_ob   <= i_in_byte;
                        r_oerr <= 1'b0;
                        r_oe   <= (r_pos == 16'd1) && (r_pad == '0);
                        if (r_pos == 16'd1) begin
                            if (r_pad != '0) begin
                                r_phase <= PH_PAD;
                            end else begin
                                r_phase <= limit_hit ? PH_STOP : PH_NEXT0;
                            end
                        end
                    end
                end
                PH_PAD: begin
                    if (in_acc) begin
                        r_pad  <= r_pad - 3'd1;
                        r_ov   <= 1'b1;
                        r_ob   <= i_in_byte;
                        r_oerr <= 1'b0;
                        r_oe   <= (r_pad == 3'd1);
                        if (r_pad == 3'd1) begin
                            r_phase <= limit_hit ? PH_STOP : PH_NEXT0;
                        end
                    end
                end
                PH_STOP: ;
                default: r_phase <= PH_STOP;
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_out_byte   = r_ob;
    assign o_packet_end = r_oe;
    assign o_sync_error = r_oerr;

    // A sync error never closes a packet
    a_err_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oerr) |-> !r_oe)
        else $error("sync error flagged together with packet end");

    // No input is taken while the header is computed or sent
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CALC || r_phase == PH_HDR) |-> o_stall)
        else $error("input taken during header build");

    // A PTS request only starts from the third frame byte
    a_calc_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pts_req.start |=> (r_phase == PH_CALC))
        else $error("PTS request without header build");

endmodule

@@ verif/aepp_checker.sv @@
// Scoreboard for the audio PES packetizer: byte-level prediction and output compare.
`timescale 1ns / 1ps
module aepp_checker
    import aepp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    input  logic                 i_stall_in,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [7:0]           i_out_byte,
    input  logic                 i_packet_end,
    input  logic                 i_sync_error,
    output int                   o_errors,
    output int                   o_pending
);

    typedef enum logic [2:0] {
        PH_HUNT0, PH_HUNT1, PH_THIRD, PH_BODY, PH_PAD, PH_NEXT0, PH_NEXT1, PH_STOPPED
    } t_phase;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_pes_byte;

    localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

    t_pes_byte   pes_q[$];

    // register copies
    logic [15:0] spf;
    logic [17:0] rate;
    logic [15:0] fsz;
    logic [32:0] offset;
    logic [47:0] limit;
    logic [7:0]  sid;

    // packetizer state
    t_phase      phase;
    logic        mpeg;
    logic [15:0] held;
    logic [15:0] remain;
    logic [2:0]  pad_left;
    logic [31:0] nframes;
    logic [47:0] pts;
    int          errors;

    function automatic logic [47:0] pts_for_frame(input logic [31:0] k);
        logic [63:0] r, a, qa, ra, v;
        r  = (rate == 0) ? 64'd1 : 64'(rate);
        a  = 64'(k) * 64'(spf);
        qa = a / r;
        ra = a % r;
        if (qa > MAX48 / 64'd90000)
            return MAX48[47:0];
        v = qa * 64'd90000 + (ra * 64'd90000) / r + 64'(offset);
        return (v > MAX48) ? MAX48[47:0] : v[47:0];
    endfunction

    function automatic logic is_mpeg_sync(input logic [7:0] b0, input logic [7:0] b1);
        return b0 == 8'hFF && b1[7:5] == 3'b111;
    endfunction

    function automatic logic is_ac3_sync(input logic [7:0] b0, input logic [7:0] b1);
        return b0 == 8'h0B && b1 == 8'h77;
    endfunction

    task automatic push(input logic [7:0] d, input logic last, input logic err);
        t_pes_byte e;
        e.data = d;
        e.last = last;
        e.err  = err;
        pes_q.push_back(e);
    endtask

    // close a packet: stop on the PTS limit, else look for the next sync
    task automatic close_packet();
        if (limit != 0 && pts >= limit)
            phase = PH_STOPPED;
        else
            phase = PH_NEXT0;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [7:0]  b0, b1;
        logic [15:0] size, len;
        logic [32:0] t;
        case (phase)
            PH_HUNT0: begin
                held  = {8'h00, b};
                phase = PH_HUNT1;
            end
            PH_HUNT1: begin
                b0 = held[7:0];
                if (is_mpeg_sync(b0, b) || is_ac3_sync(b0, b)) begin
                    mpeg  = is_mpeg_sync(b0, b);
                    held  = {b0, b};
                    pts   = 48'(offset);
                    phase = PH_THIRD;
                end else begin
                    held = {8'h00, b};
                end
            end
            PH_NEXT0: begin
                held  = {8'h00, b};
                phase = PH_NEXT1;
            end
            PH_NEXT1: begin
                b0 = held[7:0];
                if (mpeg ? is_mpeg_sync(b0, b) : is_ac3_sync(b0, b)) begin
                    held  = {b0, b};
                    phase = PH_THIRD;
                end else begin
                    push(8'h00, 1'b0, 1'b1);
                    phase = PH_STOPPED;
                end
            end
            PH_THIRD: begin
                b0 = held[15:8];
                b1 = held[7:0];
                if (mpeg && b[1])
                    pad_left = (b1[2:1] == 2'b11) ? 3'd4 : 3'd1;
                else
                    pad_left = 3'd0;
                size = (fsz < 16'd3) ? 16'd3 : fsz;
                len  = size + 16'd8 + 16'(pad_left);
                t    = pts[32:0];
                push(8'h00, 1'b0, 1'b0);
                push(8'h00, 1'b0, 1'b0);
                push(8'h01, 1'b0, 1'b0);
                push(sid, 1'b0, 1'b0);
                push(len[15:8], 1'b0, 1'b0);
                push(len[7:0], 1'b0, 1'b0);
                push(8'h81, 1'b0, 1'b0);
                push(8'h80, 1'b0, 1'b0);
                push(8'h05, 1'b0, 1'b0);
                push({4'h2, t[32:30], 1'b1}, 1'b0, 1'b0);
                push(t[29:22], 1'b0, 1'b0);
                push({t[21:15], 1'b1}, 1'b0, 1'b0);
                push(t[14:7], 1'b0, 1'b0);
                push({t[6:0], 1'b1}, 1'b0, 1'b0);
                nframes = nframes + 32'd1;
                pts     = pts_for_frame(nframes);
                push(b0, 1'b0, 1'b0);
                push(b1, 1'b0, 1'b0);
                remain = size - 16'd3;
                if (remain != 0) begin
                    push(b, 1'b0, 1'b0);
                    phase = PH_BODY;
                end else if (pad_left != 0) begin
                    push(b, 1'b0, 1'b0);
                    phase = PH_PAD;
                end else begin
                    push(b, 1'b1, 1'b0);
                    close_packet();
                end
            end
            PH_BODY: begin
                remain = remain - 16'd1;
                if (remain != 0) begin
                    push(b, 1'b0, 1'b0);
                end else if (pad_left != 0) begin
                    push(b, 1'b0, 1'b0);
                    phase = PH_PAD;
                end else begin
                    push(b, 1'b1, 1'b0);
                    close_packet();
                end
            end
            PH_PAD: begin
                pad_left = pad_left - 3'd1;
                push(b, pad_left == 3'd0, 1'b0);
                if (pad_left == 3'd0)
                    close_packet();
            end
            default: ;
        endcase
    endtask

    task automatic compare_byte();
        t_pes_byte e;
        if (pes_q.size() == 0) begin
            $error("unexpected output byte %02h", i_out_byte);
            errors++;
        end else begin
            e = pes_q.pop_front();
            if (i_out_byte !== e.data) begin
                $error("out_byte: expected %02h, got %02h", e.data, i_out_byte);
                errors++;
            end
            if (i_packet_end !== e.last) begin
                $error("packet_end: expected %0b, got %0b", e.last, i_packet_end);
                errors++;
            end
            if (i_sync_error !== e.err) begin
                $error("sync_error: expected %0b, got %0b", e.err, i_sync_error);
                errors++;
            end
        end
    endtask

    initial errors = 0;

    // track registers, predict on each accepted item, compare each output byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            spf      = 16'd1152;
            rate     = 18'd48000;
            fsz      = 16'd768;
            offset   = '0;
            limit    = '0;
            sid      = 8'd192;
            phase    = PH_HUNT0;
            mpeg     = 1'b0;
            held     = '0;
            remain   = '0;
            pad_left = '0;
            nframes  = '0;
            pts      = '0;
            pes_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                compare_byte();
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_SPF:    spf    = i_cfg_data[15:0];
                    REG_RATE:   rate   = i_cfg_data[17:0];
                    REG_FSZ:    fsz    = i_cfg_data[15:0];
                    REG_OFFSET: offset = i_cfg_data[32:0];
                    REG_LIMIT:  limit  = i_cfg_data[47:0];
                    REG_SID:    sid    = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                predict_byte(i_in_byte);
        end
        o_pending <= pes_q.size();
        o_errors  <= errors;
    end

endmodule

@@ verif/audio_es_to_pes_packetizer_tb.sv @@
// Testbench top: stream stimulus, register programming and verdict for the PES packetizer.
`timescale 1ns / 1ps
module audio_es_to_pes_packetizer_tb
    import aepp_pkg::*;
();

    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 3_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [7:0]           i_in_byte;
    logic                 o_valid;
    logic                 i_stall;
    logic [7:0]           o_out_byte;
    logic                 o_packet_end;
    logic                 o_sync_error;

    int          errors;
    int          pending;
    int          cycles;
    logic        in_taken;
    logic        idle_on;
    logic        rx_hold;
    int          rx_burst;
    logic        mpeg_stream;
    logic [15:0] frame_len;

    audio_es_to_pes_packetizer u_top (.*);

    aepp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_stall_in   (o_stall),
        .i_in_byte    (i_in_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_byte   (o_out_byte),
        .i_packet_end (o_packet_end),
        .i_sync_error (o_sync_error),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // note each accepted input item
    always @(posedge i_clk) begin
        in_taken <= i_valid && !o_stall;
    end

    // end the run on a hung block
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stall: random bursts, or a long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold) begin
            i_stall = 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst = rx_burst - 1;
            i_stall  = 1'b1;
        end else if (idle_on && $urandom_range(11) == 0) begin
            rx_burst = $urandom_range(12);
            i_stall  = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(9) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_in_byte = b;
        do @(negedge i_clk); while (!in_taken);
        i_valid = 1'b0;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_FSZ)
            frame_len = (value[15:0] < 3) ? 16'd3 : value[15:0];
    endtask

    // hold off until every predicted byte is out and the block has settled
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // one frame: sync, header bytes with layer and padding bit, body, padding
    task automatic send_frame(input logic [1:0] layer, input logic pad);
        logic [7:0] b1, b2;
        int         npad;
        b2 = 8'($urandom);
        b2[1] = pad;
        if (mpeg_stream) begin
            b1 = 8'($urandom);
            b1[7:5] = 3'b111;
            b1[2:1] = layer;
            npad = pad ? ((layer == 2'b11) ? 4 : 1) : 0;
            send_byte(8'hFF);
        end else begin
            b1 = 8'h77;
            npad = 0;
            send_byte(8'h0B);
        end
        send_byte(b1);
        send_byte(b2);
        repeat (int'(frame_len) - 3 + npad) send_byte(8'($urandom));
    endtask

    task automatic send_random_frame();
        send_frame(2'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    // garbage that cannot form a sync of either kind
    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom_range(254));
            if (b == 8'h0B)
                b = 8'h0C;
            send_byte(b);
        end
    endtask

    initial begin
        cycles      = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_in_byte   = '0;
        i_stall     = 1'b0;
        rx_hold     = 1'b0;
        rx_burst    = 0;
        idle_on     = 1'b1;
        frame_len   = 16'd768;
        mpeg_stream = 1'($urandom_range(1));
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // program small frames and an extreme offset and stream id
        write_reg(REG_SPF, 1152);
        write_reg(REG_RATE, 48000);
        write_reg(REG_FSZ, 3);
        write_reg(REG_OFFSET, 48'h1_FFFF_FFFF);
        write_reg(REG_LIMIT, 0);
        write_reg(REG_SID, 8'hFF);

        // hunt past near-miss syncs, then frames of minimum size
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'h0B);
        send_byte(8'h76);
        send_noise(2);
        send_frame(2'b11, 1'b0);
        send_frame(2'b11, 1'b1);
        send_frame(2'b10, 1'b1);
        send_frame(2'b00, 1'b1);
        drain();

        // frame size below three acts as three
        write_reg(REG_FSZ, 0);
        write_reg(REG_SID, 8'h00);
        send_frame(2'b01, 1'b1);
        drain();

        // random phases through register settings
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(REG_SPF, 16'hFFFF);
                    write_reg(REG_RATE, 1);
                end
                1: begin
                    write_reg(REG_RATE, 0);
                    write_reg(REG_OFFSET, 0);
                end
                2: begin
                    write_reg(REG_SPF, 1);
                    write_reg(REG_RATE, 18'h3FFFF);
                    write_reg(REG_LIMIT, 48'hFFFF_FFFF_FFFF);
                end
                3: begin
                    write_reg(REG_FSZ, 1);
                    write_reg(REG_SPF, 384);
                    write_reg(REG_RATE, 44100);
                end
                default: begin
                    write_reg(REG_SPF, CFG_W'($urandom_range(1, 65535)));
                    write_reg(REG_RATE, CFG_W'($urandom_range(0, 262143)));
                    write_reg(REG_OFFSET, CFG_W'({$urandom, $urandom}) & 48'h1_FFFF_FFFF);
                    write_reg(REG_SID, CFG_W'($urandom_range(255)));
                end
            endcase
            if (ph != 3)
                write_reg(REG_FSZ, CFG_W'($urandom_range(3, 14)));
            if (ph == 5) begin
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (400) @(negedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            if (ph == 7)
                idle_on = 1'b0;
            repeat (4) send_random_frame();
        end

        drain();
        write_reg(REG_FSZ, CFG_W'($urandom_range(3, 10)));

        // stop the block: missing sync, or PTS limit reached
        if ($urandom_range(1) == 0) begin
            send_random_frame();
            send_byte(8'h00);
            send_byte(8'h00);
        end else begin
            drain();
            write_reg(REG_LIMIT, 1);
            send_random_frame();
        end
        send_noise(8);

        drain();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/aepp_pkg.sv
hw/rtl/aepp_pts_unit.sv
hw/rtl/audio_es_to_pes_packetizer.sv
verif/aepp_checker.sv
verif/audio_es_to_pes_packetizer_tb.sv
